>>> rtl/pcr_pkg.sv
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared types, step indexes and the control-word program of the prime
// counter sequencer.
// ----------------------------------------------------------------------------
package pcr_pkg;

  localparam int unsigned PcWidth = 4;

  typedef logic [PcWidth-1:0] pc_t;

  // Datapath action issued by one control word
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_INIT_DIV,
    ACT_MOD_GO,
    ACT_DIV_INC,
    ACT_CNT_INC,
    ACT_V_INC,
    ACT_DONE
  } act_e;

  // Jump condition of one control word
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_V_GT_HI,
    COND_V_LT_2,
    COND_SQ_GT_V,
    COND_MOD_BUSY,
    COND_REM_ZERO
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  // Step indexes of the program
  localparam pc_t StepChkRange = pc_t'(0);
  localparam pc_t StepChkSmall = pc_t'(1);
  localparam pc_t StepChkSq    = pc_t'(2);
  localparam pc_t StepModGo    = pc_t'(3);
  localparam pc_t StepModWait  = pc_t'(4);
  localparam pc_t StepModTest  = pc_t'(5);
  localparam pc_t StepLoop     = pc_t'(6);
  localparam pc_t StepPrime    = pc_t'(7);
  localparam pc_t StepNext     = pc_t'(8);
  localparam pc_t StepDone     = pc_t'(9);

  // Program ROM: per step an action, a condition and a jump target.
  // Without a taken jump the step counter advances by one.
  function automatic ctrl_t pcr_rom(input pc_t pc);
    ctrl_t w;
    unique case (pc)
      StepChkRange: w = '{ACT_NONE,     COND_V_GT_HI,  StepDone};
      StepChkSmall: w = '{ACT_INIT_DIV, COND_V_LT_2,   StepNext};
      StepChkSq:    w = '{ACT_NONE,     COND_SQ_GT_V,  StepPrime};
      StepModGo:    w = '{ACT_MOD_GO,   COND_NEVER,    StepChkRange};
      StepModWait:  w = '{ACT_NONE,     COND_MOD_BUSY, StepModWait};
      StepModTest:  w = '{ACT_DIV_INC,  COND_REM_ZERO, StepNext};
      StepLoop:     w = '{ACT_NONE,     COND_ALWAYS,   StepChkSq};
      StepPrime:    w = '{ACT_CNT_INC,  COND_NEVER,    StepChkRange};
      StepNext:     w = '{ACT_V_INC,    COND_ALWAYS,   StepChkRange};
      StepDone:     w = '{ACT_DONE,     COND_ALWAYS,   StepChkRange};
      default:      w = '{ACT_DONE,     COND_ALWAYS,   StepChkRange};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/pcr_mod.sv
// ----------------------------------------------------------------------------
// pcr_mod
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcr_mod #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   go_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   busy_o,
  output logic [VALUE_WIDTH-1:0] rem_o
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH + 1);

  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] dvd_q, dvd_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;

  assign busy_o = (cnt_q != '0);
  assign rem_o  = rem_q;

  assign trial = {rem_q, dvd_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    if (go_i) begin
      cnt_d = CntWidth'(VALUE_WIDTH);
      dvd_d = dividend_i;
      rem_d = '0;
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
      dvd_d = {dvd_q[VALUE_WIDTH-2:0], 1'b0};
      // partial remainder stays below the divisor, so it fits in VALUE_WIDTH
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[VALUE_WIDTH-1:0];
      end else begin
        rem_d = trial[VALUE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

endmodule

>>> rtl/prime_count_in_range.sv
// ----------------------------------------------------------------------------
// prime_count_in_range
// Counts the primes in an inclusive range by trial division, driven by a
// small microcode program.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with range_low_i / range_high_i while busy is low; the
//   transaction is taken at that clock edge and busy rises. When the count
//   is ready, done_o pulses for one cycle with prime_count_o valid, and busy
//   falls in the same cycle, so the next start can follow right away.
//   The result is never held back: the receiver must take it on the pulse.
// Run time: data dependent. Per value in the range the program checks the
//   range and small values; per trial divisor (2 up to sqrt(value)) it
//   starts the bit-serial remainder unit (one quotient bit per cycle),
//   waits on it and tests the remainder. An empty range answers 0 without
//   any trial division.
// One transaction at a time; start is ignored while busy.
// Reset: rst_ni (async, active low) clears busy, the strobe and the step
//   counter; no clearing pass is needed.
// ----------------------------------------------------------------------------
module prime_count_in_range
  import pcr_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] range_low_i,
  input  logic [VALUE_WIDTH-1:0] range_high_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH:0]   prime_count_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  pc_t                    pc_q, pc_d;
  logic [VALUE_WIDTH:0]   v_q, v_d;
  logic [VALUE_WIDTH-1:0] hi_q, hi_d;
  logic [VALUE_WIDTH-1:0] div_q, div_d;
  logic [VALUE_WIDTH+1:0] sq_q, sq_d;
  logic [VALUE_WIDTH:0]   cnt_q, cnt_d;

  ctrl_t                  ctrl;
  logic                   cond_hit;
  logic                   accept;
  logic                   mod_go;
  logic                   mod_busy;
  logic [VALUE_WIDTH-1:0] mod_rem;

  assign accept        = start && !busy_q;
  assign busy          = busy_q;
  assign done_o        = done_q;
  assign prime_count_o = cnt_q;

  assign ctrl   = pcr_rom(pc_q);
  assign mod_go = busy_q && (ctrl.act == ACT_MOD_GO);

  pcr_mod #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (mod_go),
    .dividend_i (v_q[VALUE_WIDTH-1:0]),
    .divisor_i  (div_q),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_V_GT_HI:  cond_hit = (v_q > {1'b0, hi_q});
      COND_V_LT_2:   cond_hit = (v_q < (VALUE_WIDTH+1)'(2));
      COND_SQ_GT_V:  cond_hit = (sq_q > {1'b0, v_q});
      COND_MOD_BUSY: cond_hit = mod_busy;
      COND_REM_ZERO: cond_hit = (mod_rem == '0);
      default:       cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    pc_d   = pc_q;
    v_d    = v_q;
    hi_d   = hi_q;
    div_d  = div_q;
    sq_d   = sq_q;
    cnt_d  = cnt_q;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = StepChkRange;
      v_d    = {1'b0, range_low_i};
      hi_d   = range_high_i;
      cnt_d  = '0;
    end else if (busy_q) begin
      pc_d = cond_hit ? ctrl.target : pc_t'(pc_q + 1'b1);
      unique case (ctrl.act)
        ACT_NONE:     ;
        ACT_MOD_GO:   ;
        ACT_INIT_DIV: begin
          div_d = VALUE_WIDTH'(2);
          sq_d  = (VALUE_WIDTH+2)'(4);
        end
        ACT_DIV_INC: begin
          // (d+1)^2 = d^2 + 2d + 1
          div_d = div_q + 1'b1;
          sq_d  = sq_q + (VALUE_WIDTH+2)'({div_q, 1'b1});
        end
        ACT_CNT_INC:  cnt_d = cnt_q + 1'b1;
        ACT_V_INC:    v_d   = v_q + 1'b1;
        ACT_DONE: begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pc_q   <= StepChkRange;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      pc_q   <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    hi_q  <= hi_d;
    div_q <= div_d;
    sq_q  <= sq_d;
    cnt_q <= cnt_d;
  end

`ifndef SYNTH
  // result strobe and busy release happen together
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("done without a running transaction");

  // a new transaction starts the program with a cleared count
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy && (pc_q == StepChkRange) && (prime_count_o == '0))
    else $error("transaction start did not initialize");

  // the remainder unit only runs while the program waits on it
  a_mod_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_busy |-> busy_q && (pc_q == StepModWait))
    else $error("remainder unit busy outside the wait step");
`endif

endmodule

>>> bench/prime_count_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_count_checker
// Watches the command and result ports of prime_count_in_range, works out
// the prime count of every accepted range by trial division and compares
// each strobed result against the oldest open count.
// ----------------------------------------------------------------------------
module prime_count_checker #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic [VALUE_WIDTH-1:0] range_low_i,
  input  logic [VALUE_WIDTH-1:0] range_high_i,
  input  logic                   done_i,
  input  logic [VALUE_WIDTH:0]   prime_count_i,
  output int unsigned            error_count_o,
  output int unsigned            open_count_o
);

  localparam longint unsigned SmallestPrime = 2;

  logic [VALUE_WIDTH:0] open_counts_q[$];
  int unsigned          errors = 0;
  int unsigned          open_n = 0;

  assign error_count_o = errors;
  assign open_count_o  = open_n;

  function automatic logic [VALUE_WIDTH:0] primes_in_range(
    input logic [VALUE_WIDTH-1:0] lo,
    input logic [VALUE_WIDTH-1:0] hi
  );
    longint unsigned      v;
    longint unsigned      d;
    logic [VALUE_WIDTH:0] n;
    bit                   is_prime;
    n = '0;
    // wide loop variable so hi at full scale does not wrap
    for (v = longint'(lo); v <= longint'(hi); v++) begin
      is_prime = (v >= SmallestPrime);
      for (d = SmallestPrime; is_prime && d * d <= v; d++) begin
        if (v % d == 0) is_prime = 0;
      end
      if (is_prime) n++;
    end
    return n;
  endfunction

  task automatic flag_error(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    logic [VALUE_WIDTH:0] want;
    if (rst_ni) begin
      if (done_i) begin
        if (open_counts_q.size() == 0) begin
          flag_error($sformatf("result %0d with no transaction open", prime_count_i));
        end else begin
          want = open_counts_q.pop_front();
          if (prime_count_i !== want) begin
            flag_error($sformatf("prime_count %0d, expected %0d", prime_count_i, want));
          end
        end
      end
      if (start_i && !busy_i) begin
        open_counts_q.push_back(primes_in_range(range_low_i, range_high_i));
      end
      open_n <= open_counts_q.size();
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for prime_count_in_range: directed corner ranges, then random
// ranges in three phases of sender idling, with a drain between phases.
// Results are checked by prime_count_checker; a stall watchdog ends the run.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned VALUE_WIDTH  = 16;
  localparam int          ValueMax     = (1 << VALUE_WIDTH) - 1;
  localparam int unsigned StallLimit   = 500000;
  localparam int unsigned ItemsPerPass = 28;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [VALUE_WIDTH-1:0] range_low_i;
  logic [VALUE_WIDTH-1:0] range_high_i;
  logic                   done_o;
  logic [VALUE_WIDTH:0]   prime_count_o;

  int unsigned error_count;
  int unsigned open_count;
  int unsigned stall_cycles = 0;
  int unsigned idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  prime_count_in_range #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .done_o       (done_o),
    .prime_count_o(prime_count_o)
  );

  prime_count_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .done_i       (done_o),
    .prime_count_i(prime_count_o),
    .error_count_o(error_count),
    .open_count_o (open_count)
  );

  // Stall watchdog: cycles with neither a command nor a result taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("prime_count_in_range regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Issue one range; start is left high and the task waits until busy is seen low
  task automatic send_range(input int lo, input int hi);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
    start        <= 1'b1;
    range_low_i  <= VALUE_WIDTH'(lo);
    range_high_i <= VALUE_WIDTH'(hi);
    do @(posedge clk_i); while (busy);
  endtask

  // Hold off until every open count has been answered
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (open_count != 0);
  endtask

  task automatic send_random_range();
    int sel;
    int lo;
    int hi;
    sel = $urandom_range(99);
    if (sel < 65) begin
      // narrow window anywhere in the value space
      lo = $urandom_range(0, ValueMax);
      hi = lo + $urandom_range(0, 15);
      if (hi > ValueMax) hi = ValueMax;
    end else if (sel < 80) begin
      // empty range
      lo = $urandom_range(1, ValueMax);
      hi = $urandom_range(0, lo - 1);
    end else if (sel < 95) begin
      lo = $urandom_range(0, 200);
      hi = lo + $urandom_range(0, 100);
    end else begin
      lo = $urandom_range(0, ValueMax);
      hi = lo;
    end
    send_range(lo, hi);
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    range_low_i  = '0;
    range_high_i = '0;
    idle_pct     = 33;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero and one are not prime
    send_range(0, 0);
    send_range(1, 1);
    send_range(0, 1);
    send_range(2, 2);
    send_range(0, 2);
    send_range(3, 3);
    send_range(4, 4);
    send_range(0, 100);
    send_range(0, 255);
    send_range(251, 256);
    // empty ranges, including the full-scale inversion
    send_range(1, 0);
    send_range(ValueMax, 0);
    send_range(ValueMax, ValueMax - 1);
    // top of the value space
    send_range(ValueMax, ValueMax);
    send_range(65521, ValueMax);
    send_range(32768, 32800);
    send_range('h5555, 'h5560);
    send_range('hAAAA, 'hAAB0);

    for (int pass = 0; pass < 3; pass++) begin
      idle_pct = (pass == 0) ? 33 : (pass == 1) ? 66 : 0;
      for (int i = 0; i < ItemsPerPass; i++) send_random_range();
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (error_count == 0 && open_count == 0) begin
      $display("prime_count_in_range regression: pass");
    end else begin
      $display("prime_count_in_range regression: fail");
    end
    $finish;
  end

endmodule
